FILE: hw/rtl/adsr_envelope_generator_macros.svh
// -----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i; ADSR_ASSERT is disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define ADSR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adsr assertion failed");

// Assertion that is also checked while reset is asserted.
`define ADSR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("adsr assertion failed");

`endif

FILE: hw/rtl/adsr_pkg.sv
// -----------------------------------------------------------------------------
// ADSR envelope generator package
// Widths, phase codes, register indexes and the configuration bundle.
// -----------------------------------------------------------------------------
package adsr_pkg;

  localparam int unsigned LevelW   = 31;
  localparam int unsigned StepW    = 31;
  localparam int unsigned SusW     = 15;
  localparam int unsigned OutW     = 15;
  localparam int unsigned OutShift = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 31;

  localparam logic [LevelW-1:0] LevelFull = {LevelW{1'b1}};

  typedef enum logic [1:0] {
    PhAttack  = 2'd0,
    PhDecay   = 2'd1,
    PhSustain = 2'd2,
    PhRelease = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAttackStep   = 4'd0,
    CfgDecayStep    = 4'd1,
    CfgReleaseStep  = 4'd2,
    CfgSustainLevel = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [StepW-1:0] attack_step;
    logic [StepW-1:0] decay_step;
    logic [StepW-1:0] release_step;
    logic [SusW-1:0]  sustain_level;
  } adsr_cfg_t;

endpackage

FILE: hw/rtl/adsr_envelope_generator.sv
// -----------------------------------------------------------------------------
// ADSR envelope generator
// An accepted gate bit waits in gate_q; its envelope is then registered in envelope_q.
// Throughput: one sample per cycle unless stalled; level and phase update on each advance.
// The input stalls only while the output register is full and stalled.
// Reset zeroes the level, enters release and clears the valid and config registers.
// -----------------------------------------------------------------------------
module adsr_envelope_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [adsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [adsr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          gate_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [adsr_pkg::OutW-1:0]     envelope_o
);
  import adsr_pkg::*;

  adsr_cfg_t         cfg;
  logic              in_valid_d, in_valid_q;
  logic              gate_q;
  logic              out_valid_d, out_valid_q;
  logic [OutW-1:0]   envelope_q;
  logic [LevelW-1:0] level_d, level_q;
  phase_e            phase_d, phase_q;
  logic              in_accept;
  logic              out_free;
  logic              advance;

  adsr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  adsr_step u_step (
    .cfg_i   (cfg),
    .gate_i  (gate_q),
    .level_i (level_q),
    .phase_i (phase_q),
    .level_o (level_d),
    .phase_o (phase_d)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      phase_q     <= PhRelease;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        level_q <= level_d;
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      gate_q <= gate_i;
    end
    if (advance) begin
      envelope_q <= level_d[OutShift +: OutW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign envelope_o  = envelope_q;

endmodule

FILE: hw/rtl/adsr_cfg_regs.sv
// -----------------------------------------------------------------------------
// ADSR configuration registers
// Holds the attack, decay and release steps and the sustain level.
// -----------------------------------------------------------------------------
module adsr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [adsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [adsr_pkg::CfgDataW-1:0] cfg_data_i,
  output adsr_pkg::adsr_cfg_t           cfg_o
);
  import adsr_pkg::*;

  adsr_cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgAttackStep:   cfg_d.attack_step   = cfg_data_i[StepW-1:0];
        CfgDecayStep:    cfg_d.decay_step    = cfg_data_i[StepW-1:0];
        CfgReleaseStep:  cfg_d.release_step  = cfg_data_i[StepW-1:0];
        CfgSustainLevel: cfg_d.sustain_level = cfg_data_i[SusW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/adsr_step.sv
// -----------------------------------------------------------------------------
// ADSR step logic
// Computes the next phase and level for one sample from the gate bit.
// -----------------------------------------------------------------------------
module adsr_step (
  input  adsr_pkg::adsr_cfg_t         cfg_i,
  input  logic                        gate_i,
  input  logic [adsr_pkg::LevelW-1:0] level_i,
  input  adsr_pkg::phase_e            phase_i,
  output logic [adsr_pkg::LevelW-1:0] level_o,
  output adsr_pkg::phase_e            phase_o
);
  import adsr_pkg::*;

  phase_e            phase_gated;
  logic [LevelW-1:0] sus_level;
  logic [LevelW:0]   attack_sum;
  logic [LevelW:0]   decay_floor;
  logic              decay_done;
  logic              release_done;

  always_comb begin
    phase_gated = phase_i;
    if (phase_i == PhRelease && gate_i) begin
      phase_gated = PhAttack;
    end else if (phase_i != PhRelease && !gate_i) begin
      phase_gated = PhRelease;
    end
  end

  assign sus_level    = {cfg_i.sustain_level, {(LevelW-SusW){1'b0}}};
  assign attack_sum   = {1'b0, level_i} + {1'b0, cfg_i.attack_step};
  assign decay_floor  = {1'b0, sus_level} + {1'b0, cfg_i.decay_step};
  assign decay_done   = decay_floor[LevelW] || (decay_floor[LevelW-1:0] > level_i);
  assign release_done = cfg_i.release_step > level_i;

  always_comb begin
    level_o = level_i;
    phase_o = phase_gated;
    case (phase_gated)
      PhAttack: begin
        if (attack_sum[LevelW]) begin
          level_o = LevelFull;
          phase_o = PhDecay;
        end else begin
          level_o = attack_sum[LevelW-1:0];
        end
      end
      PhDecay: begin
        if (decay_done) begin
          level_o = sus_level;
          phase_o = PhSustain;
        end else begin
          level_o = level_i - cfg_i.decay_step;
        end
      end
      PhRelease: begin
        if (release_done) begin
          level_o = '0;
        end else begin
          level_o = level_i - cfg_i.release_step;
        end
      end
      default: level_o = level_i;
    endcase
  end

endmodule

FILE: hw/rtl/adsr_checker.sv
// -----------------------------------------------------------------------------
// ADSR envelope generator port checker
// Checks the handshake behavior seen on the top-level ports.
// -----------------------------------------------------------------------------
`include "adsr_envelope_generator_macros.svh"

module adsr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_ready_o,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [adsr_pkg::OutW-1:0]    envelope_o
);

  `ADSR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(envelope_o))
  `ADSR_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)
  `ADSR_ASSERT(a_out_from_request, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
  `ADSR_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o)

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (.*);

FILE: sim/tb_adsr_envelope_generator.sv
// -----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives gate samples and register writes into the block while both handshake
// sides idle at random. A software model of the envelope predicts every output
// sample, and each accepted sample is checked against the oldest prediction.
// -----------------------------------------------------------------------------
module tb_adsr_envelope_generator;
  import adsr_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseCount = 12;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned MaxPrinted = 40;

  class envelope_scoreboard;
    logic [StepW-1:0]  attack_step;
    logic [StepW-1:0]  decay_step;
    logic [StepW-1:0]  release_step;
    logic [SusW-1:0]   sustain_q15;
    logic [LevelW-1:0] level;
    phase_e            phase;
    logic [OutW-1:0]   pending_env[$];
    int unsigned       errors;

    function new();
      attack_step  = '0;
      decay_step   = '0;
      release_step = '0;
      sustain_q15  = '0;
      level        = '0;
      phase        = PhRelease;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return pending_env.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgAttackStep:   attack_step  = data[StepW-1:0];
        CfgDecayStep:    decay_step   = data[StepW-1:0];
        CfgReleaseStep:  release_step = data[StepW-1:0];
        CfgSustainLevel: sustain_q15  = data[SusW-1:0];
        default: ;
      endcase
    endfunction

    function void note_gate(logic gate);
      logic [LevelW-1:0] sus;
      logic [LevelW:0]   floor_sum;
      sus = {sustain_q15, 16'b0};
      if (phase == PhRelease && gate) begin
        phase = PhAttack;
      end else if (phase != PhRelease && !gate) begin
        phase = PhRelease;
      end
      case (phase)
        PhAttack: begin
          if (LevelFull - attack_step < level) begin
            level = LevelFull;
            phase = PhDecay;
          end else begin
            level = level + attack_step;
          end
        end
        PhDecay: begin
          floor_sum = {1'b0, sus} + {1'b0, decay_step};
          if (floor_sum > {1'b0, LevelFull} || floor_sum > {1'b0, level}) begin
            level = sus;
            phase = PhSustain;
          end else begin
            level = level - decay_step;
          end
        end
        PhRelease: begin
          if (release_step > level) begin
            level = '0;
          end else begin
            level = level - release_step;
          end
        end
        default: ;
      endcase
      pending_env.push_back(level[LevelW-1:OutShift]);
    endfunction

    task report(string line);
      if (errors < MaxPrinted) begin
        $display("%s", line);
      end
      errors++;
    endtask

    task check_envelope(logic [OutW-1:0] env);
      logic [OutW-1:0] want;
      if (pending_env.size() == 0) begin
        report($sformatf("envelope %h arrived with nothing predicted", env));
      end else begin
        want = pending_env.pop_front();
        if (env !== want) begin
          report($sformatf("envelope mismatch: got %h, predicted %h", env, want));
        end
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                gate_i      = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [OutW-1:0]     envelope_o;

  envelope_scoreboard sb = new();
  bit                 idle_on   = 1'b0;
  int unsigned        stall_cnt = 0;
  int unsigned        cycles    = 0;
  int unsigned        phase_n   = 0;

  adsr_envelope_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .gate_i      (gate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .envelope_o  (envelope_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_adsr_envelope_generator: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!idle_on || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt   <= 0;
    end else if (stall_cnt != 0) begin
      out_stall_i <= 1'b1;
      stall_cnt   <= stall_cnt - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_cnt   <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_envelope(envelope_o);
    end
  end

  function automatic logic [StepW-1:0] pick_step();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0:       r = 32'd0;
      1:       r = {1'b0, LevelFull};
      2:       r = $urandom;
      3:       r = $urandom_range(1, 4095);
      default: r = $urandom_range(32'h0200_0000, 32'h7FFF_FFFF);
    endcase
    return r[StepW-1:0];
  endfunction

  function automatic logic [CfgDataW-1:0] pick_sustain();
    logic [31:0] r;
    logic [SusW-1:0] sus;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       sus = '0;
      1:       sus = '1;
      default: sus = r[30:16];
    endcase
    return {r[15:0], sus};
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic send_gate(input logic g);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    gate_i     <= g;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_gate(g);
    phase_n++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_all(input logic [StepW-1:0] atk, input logic [StepW-1:0] dec,
                           input logic [StepW-1:0] rel, input logic [CfgDataW-1:0] sus);
    write_reg(CfgAttackStep, atk);
    write_reg(CfgDecayStep, dec);
    write_reg(CfgReleaseStep, rel);
    write_reg(CfgSustainLevel, sus);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic g;
    int unsigned run;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All registers at their reset value: zero steps hold the level in every phase.
    idle_on = 1'b1;
    send_gate(1'b0);
    send_gate(1'b1);
    send_gate(1'b1);
    send_gate(1'b0);
    drain_results();

    write_all(31'h4000_0000, 31'h1000_0000, 31'h2000_0000, 31'h0000_4000);
    repeat (8) send_gate(1'b1);
    repeat (4) send_gate(1'b0);
    send_gate(1'b1);
    send_gate(1'b0);
    send_gate(1'b1);
    drain_results();

    write_all(LevelFull, LevelFull, LevelFull, 31'h7FFF_FFFF);
    send_gate(1'b0);
    repeat (3) send_gate(1'b1);
    repeat (2) send_gate(1'b0);
    drain_results();

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      idle_on = (ph + 2 < PhaseCount) && ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        write_all('0, '0, '0, '0);
      end else if (ph == 1) begin
        write_all(LevelFull, LevelFull, LevelFull, '1);
      end else begin
        if ($urandom_range(0, 1)) write_reg(CfgAttackStep, pick_step());
        if ($urandom_range(0, 1)) write_reg(CfgDecayStep, pick_step());
        if ($urandom_range(0, 1)) write_reg(CfgReleaseStep, pick_step());
        if ($urandom_range(0, 1)) write_reg(CfgSustainLevel, pick_sustain());
        if ($urandom_range(0, 2) == 0) begin
          write_reg(CfgIdxW'($urandom_range(4, 15)), CfgDataW'($urandom));
        end
        cfg_valid_i <= 1'b0;
      end
      phase_n = 0;
      while (phase_n < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            g = 1'($urandom_range(0, 1));
            send_gate(g);
          end
        end else begin
          run = $urandom_range(1, 60);
          repeat (run) send_gate(1'b1);
          run = $urandom_range(1, 30);
          repeat (run) send_gate(1'b0);
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_adsr_envelope_generator: done, clean");
    end else begin
      $display("tb_adsr_envelope_generator: done, errors");
    end
    $finish;
  end

endmodule
